>>> design/sortb_pkg.sv
// Shared types, codes and constants for the sorted table binary search block.
`default_nettype none

package sortb_pkg;

    // Fixed field widths of the request and response payloads.
    localparam int WORD_W = 32;
    localparam int IDX_W  = 10;
    localparam int CFG_W  = 11;

    // Default number of table entries held in the memory.
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // Operation codes carried in the func field.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [IDX_W-1:0]         entry_index;
        logic signed [WORD_W-1:0] entry_value;
        logic signed [WORD_W-1:0] search_key;
    } sortb_req_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } sortb_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_FINISH
    } sortb_state_t;

endpackage : sortb_pkg

`default_nettype wire

>>> design/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
`default_nettype none

// The block keeps a table of TABLE_DEPTH signed 32-bit entries in a single-port-read,
// single-port-write synchronous memory, which software fills in ascending order with
// write requests (func = 0). A write request gives no response; one whose entry_index
// is not below TABLE_DEPTH is dropped. A search request (func = 1) runs a binary
// search over entries 0 to entries_in_use-1, where entries_in_use is saturated at
// TABLE_DEPTH, and gives exactly one response: found and the matching index, or
// found = 0 with index 0. The search is bounded by the memory read port: each probe
// is one registered read, and the compare of the returned word selects the next
// address in the same cycle; a search makes at most floor(log2(entries_in_use)) + 1
// probes (11 for a full table of 1024) and none on an empty table. Requests are
// taken one at a time; a new request is accepted as soon as the previous search has
// handed its response to the output register, even while that response still waits
// for rsp_ready. The memory has no reset and needs no clearing pass; entries that
// were never written must not be searched. The user must write entries_in_use
// through cfg_we and cfg_wdata only while no request is in flight; the block itself
// does not enforce this.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sortb_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sortb_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire sortb_pkg::sortb_req_t           req,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output sortb_pkg::sortb_rsp_t                rsp
);

    import sortb_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // Configuration register holding entries_in_use.
    logic [CFG_W-1:0] cfg_reg;

    // Output register that decouples the response from the search sequencer.
    logic        rsp_valid_reg, rsp_valid_next;
    sortb_rsp_t  rsp_reg;

    logic              req_fire;
    logic              wr_en;
    logic              search_start;
    logic [31:0]       cfg_wide;
    logic [CNT_W-1:0]  count;

    logic              srch_busy;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              res_valid;
    logic              res_ready;
    sortb_rsp_t        res;

    // A request is only taken while the sequencer is idle, so a write and a probe
    // read never meet in the same cycle and a search always sees earlier writes.
    assign req_ready    = !srch_busy;
    assign req_fire     = req_valid && req_ready;
    assign wr_en        = req_fire && (req.func == FUNC_WRITE)
                        && (32'(req.entry_index) < 32'(TABLE_DEPTH));
    assign search_start = req_fire && (req.func == FUNC_SEARCH);

    // Counts above the table size are clamped to the table size.
    assign cfg_wide = 32'(cfg_reg);
    assign count    = (cfg_wide > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cfg_wide);

    sortb_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(req.entry_index)),
        .wr_data (req.entry_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sortb_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (search_start),
        .key       (req.search_key),
        .count     (count),
        .busy      (srch_busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The sequencer may hand over its result whenever the output register is empty
    // or is being emptied in this cycle.
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A probe never addresses an entry outside the searched range.
    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (CNT_W'(rd_addr) < count))
        else $error("probe address outside the searched range");

    // A miss always reports index zero.
    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.found) |-> (rsp.match_index == '0))
        else $error("miss response with non-zero index");

    // A search over an empty table offers a miss in the very next cycle.
    a_empty_table_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (search_start && (count == '0)) |=> (res_valid && !res.found))
        else $error("empty table search did not give an immediate miss");

    // A probe read is issued only while a search is starting or running.
    a_read_only_when_searching: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (search_start || srch_busy))
        else $error("memory read outside a search");

endmodule : sorted_table_binary_search

`default_nettype wire

>>> design/sortb_mem.sv
// Table memory: one write port and one read port with registered read data.
`default_nettype none

module sortb_mem #(
    parameter int TABLE_DEPTH = sortb_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                                           clk,
    input  wire logic                                           wr_en,
    input  wire logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [sortb_pkg::WORD_W-1:0]                   wr_data,
    input  wire logic                                           rd_en,
    input  wire logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
    output logic      [sortb_pkg::WORD_W-1:0]                   rd_data
);

    import sortb_pkg::*;

    logic [WORD_W-1:0] mem_array [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_array[rd_addr];
        end
    end

endmodule : sortb_mem

`default_nettype wire

>>> design/sortb_search.sv
// Binary search sequencer: keeps the bounds, issues one memory read per probe.
`default_nettype none

module sortb_search #(
    parameter int TABLE_DEPTH = sortb_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           start,
    input  wire logic signed [sortb_pkg::WORD_W-1:0]            key,
    input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]               count,
    output logic                                                busy,
    output logic                                                rd_en,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
    input  wire logic [sortb_pkg::WORD_W-1:0]                   rd_data,
    output logic                                                res_valid,
    input  wire logic                                           res_ready,
    output sortb_pkg::sortb_rsp_t                               res
);

    import sortb_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    sortb_state_t state_reg, state_next;

    // Bounds are kept as [low, high) so that they never go negative.
    logic [CNT_W-1:0]         low_reg, low_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [ADDR_W-1:0]        mid_reg, mid_next;
    logic signed [WORD_W-1:0] key_reg;
    logic                     found_reg;
    logic [IDX_W-1:0]         idx_reg;

    logic             key_lt, key_gt, key_eq;
    logic             more_probes;
    logic [CNT_W:0]   mid_sum;

    assign key_lt = key_reg < $signed(rd_data);
    assign key_gt = key_reg > $signed(rd_data);
    assign key_eq = !key_lt && !key_gt;

    // Bound update and the next midpoint.
    always_comb
    begin
        low_next = low_reg;
        hi_next  = hi_reg;
        if (state_reg == ST_IDLE)
        begin
            low_next = '0;
            hi_next  = count;
        end
        else if (key_gt)
        begin
            low_next = CNT_W'(mid_reg) + CNT_W'(1);
        end
        else if (key_lt)
        begin
            hi_next = CNT_W'(mid_reg);
        end
        mid_sum     = {1'b0, low_next} + {1'b0, hi_next} - (CNT_W + 1)'(1);
        mid_next    = ADDR_W'(mid_sum >> 1);
        more_probes = low_next < hi_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (count == '0) ? ST_FINISH : ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (key_eq || !more_probes)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        res_valid = (state_reg == ST_FINISH);
        rd_addr   = mid_next;
        rd_en     = ((state_reg == ST_IDLE) && start && (count != '0))
                  || ((state_reg == ST_PROBE) && !key_eq && more_probes);
        res.found       = found_reg;
        res.match_index = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            key_reg   <= key;
            low_reg   <= low_next;
            hi_reg    <= hi_next;
            mid_reg   <= mid_next;
            found_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (state_reg == ST_PROBE)
        begin
            low_reg <= low_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
            if (key_eq)
            begin
                found_reg <= 1'b1;
                idx_reg   <= IDX_W'(mid_reg);
            end
        end
    end

endmodule : sortb_search

`default_nettype wire
